// ===== rtl/zsa_pkg.sv =====
// Shared types and constants for the zonal statistics accumulator.
`timescale 1ns / 1ps

package zsa_pkg;

    localparam int ZONES_DEFAULT = 256;
    localparam int ZONE_COUNT_W  = 9;
    localparam int CFG_DATA_W    = 32;

    typedef enum logic [0:0] {
        REG_ZONE_OFFSET = 1'b0,
        REG_ZONE_COUNT  = 1'b1
    } zsa_reg_t;

    typedef struct packed {
        logic        [31:0] cell_count;
        logic        [31:0] valid_count;
        logic signed [63:0] sum;
        logic        [63:0] sum_sq;
        logic        [63:0] sum_abs;
        logic signed [31:0] minimum;
        logic signed [31:0] maximum;
    } zsa_entry_t;

    localparam int ENTRY_W = $bits(zsa_entry_t);

    localparam zsa_entry_t ENTRY_RESET = '{
        cell_count:  32'd0,
        valid_count: 32'd0,
        sum:         64'sd0,
        sum_sq:      64'd0,
        sum_abs:     64'd0,
        minimum:     32'sh7fff_ffff,
        maximum:     32'sh8000_0000
    };

endpackage

// ===== rtl/zsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module zsa_ram
    #(parameter int WIDTH = 32,
      parameter int DEPTH = 256,
      parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/zonal_stats_accumulator_unit.sv =====
// Top level of the zonal statistics accumulator: per-zone table in one RAM.
// Result: registered from the S_READ state that follows acceptance (table read, then
// update); S_READ holds while the previous result is still stalled at the output.
// Items: a new item is taken only in S_IDLE, once the table RAM update of the last one is done.
// Reset: registers clear at once; then a clearing pass writes every
// table entry while in_stall stays high. Configuration writes are taken during it.
`timescale 1ns / 1ps

module zonal_stats_accumulator_unit
    #(parameter int ZONES = zsa_pkg::ZONES_DEFAULT)
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_write_en,
    input  zsa_pkg::zsa_reg_t               cfg_index,
    input  logic [zsa_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [31:0]              sample_value,
    input  logic                            sample_is_null,
    input  logic signed [31:0]              zone_number,
    input  logic                            zone_is_null,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      zone_index,
    output logic                            skipped,
    output logic                            out_of_range,
    output logic [31:0]                     cell_count,
    output logic [31:0]                     valid_count,
    output logic signed [63:0]              sum,
    output logic [63:0]                     sum_sq,
    output logic [63:0]                     sum_abs,
    output logic signed [31:0]              minimum,
    output logic signed [31:0]              maximum
);

    import zsa_pkg::*;

    localparam int IDX_W  = (ZONES > 1) ? $clog2(ZONES) : 1;
    localparam int CNT_W  = ($clog2(ZONES + 1) > ZONE_COUNT_W) ? $clog2(ZONES + 1)
                                                                : ZONE_COUNT_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ
    } state_t;

    state_t                 state_reg;
    logic [IDX_W-1:0]       clr_addr_reg;
    logic signed [31:0]     zone_offset_reg;
    logic [ZONE_COUNT_W-1:0] zone_count_reg;

    logic signed [31:0]     sample_reg;
    logic                   sample_null_reg;
    logic [31:0]            mag_reg;
    logic [63:0]            sq_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic                   skip_reg;
    logic                   oor_reg;

    logic                   out_valid_reg;
    logic [7:0]             zone_index_reg;
    logic                   skipped_reg;
    logic                   out_of_range_reg;
    zsa_entry_t             result_reg;

    logic                   accept;
    logic                   load_out;
    logic [CNT_W-1:0]       count_eff;
    logic                   zoning;
    logic [32:0]            diff;
    logic                   diff_oor;
    logic                   in_skip;
    logic                   in_oor;
    logic [IDX_W-1:0]       in_idx;
    logic [31:0]            in_mag;
    logic [63:0]            in_sq;

    logic                   ram_wr_en;
    logic [IDX_W-1:0]       ram_wr_addr;
    zsa_entry_t             ram_wr_data;
    logic [ENTRY_W-1:0]     ram_rd_data;
    zsa_entry_t             rd_entry;
    zsa_entry_t             upd_next;

    logic signed [64:0]     sum_ext;
    logic [64:0]            sq_ext;
    logic [64:0]            abs_ext;

    // front end: zone decode and squaring of the sample
    always_comb
    begin
        if (CNT_W'(zone_count_reg) > CNT_W'(ZONES))
        begin
            count_eff = CNT_W'(ZONES);
        end
        else
        begin
            count_eff = CNT_W'(zone_count_reg);
        end
        zoning   = (count_eff != '0);
        diff     = {zone_number[31], zone_number} - {zone_offset_reg[31], zone_offset_reg};
        diff_oor = diff[32] || (diff >= 33'(count_eff));
        in_skip  = zoning && (zone_is_null || diff_oor);
        in_oor   = zoning && !zone_is_null && diff_oor;
        in_idx   = zoning ? diff[IDX_W-1:0] : '0;
        in_mag   = sample_value[31] ? (~sample_value + 32'd1) : sample_value;
        in_sq    = 64'(in_mag) * 64'(in_mag);
    end

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign load_out = (state_reg == S_READ) && (!out_valid_reg || !out_stall);

    // entry update
    assign rd_entry = zsa_entry_t'(ram_rd_data);

    always_comb
    begin
        upd_next = rd_entry;
        sum_ext  = {rd_entry.sum[63], rd_entry.sum} + {{33{sample_reg[31]}}, sample_reg};
        sq_ext   = {1'b0, rd_entry.sum_sq} + {1'b0, sq_reg};
        abs_ext  = {1'b0, rd_entry.sum_abs} + 65'(mag_reg);

        if (rd_entry.cell_count != 32'hffff_ffff)
        begin
            upd_next.cell_count = rd_entry.cell_count + 32'd1;
        end

        if (!sample_null_reg)
        begin
            if (rd_entry.valid_count != 32'hffff_ffff)
            begin
                upd_next.valid_count = rd_entry.valid_count + 32'd1;
            end
            if (sum_ext[64] != sum_ext[63])
            begin
                upd_next.sum = sum_ext[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end
            else
            begin
                upd_next.sum = sum_ext[63:0];
            end
            upd_next.sum_sq  = sq_ext[64] ? '1 : sq_ext[63:0];
            upd_next.sum_abs = abs_ext[64] ? '1 : abs_ext[63:0];
            if (sample_reg < rd_entry.minimum)
            begin
                upd_next.minimum = sample_reg;
            end
            if (sample_reg > rd_entry.maximum)
            begin
                upd_next.maximum = sample_reg;
            end
        end
    end

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_reg;
            ram_wr_data = ENTRY_RESET;
        end
        else
        begin
            ram_wr_en   = load_out && !skip_reg;
            ram_wr_addr = idx_reg;
            ram_wr_data = upd_next;
        end
    end

    zsa_ram
        #(.WIDTH (ENTRY_W),
          .DEPTH (ZONES),
          .AW    (IDX_W))
    u_table
    (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (in_idx),
        .rd_data (ram_rd_data)
    );

    // control, configuration and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_addr_reg     <= '0;
            zone_offset_reg  <= '0;
            zone_count_reg   <= '0;
            sample_reg       <= '0;
            sample_null_reg  <= 1'b0;
            mag_reg          <= '0;
            sq_reg           <= '0;
            idx_reg          <= '0;
            skip_reg         <= 1'b0;
            oor_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
            zone_index_reg   <= '0;
            skipped_reg      <= 1'b0;
            out_of_range_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_ZONE_OFFSET: zone_offset_reg <= cfg_data[31:0];
                    REG_ZONE_COUNT:  zone_count_reg  <= cfg_data[ZONE_COUNT_W-1:0];
                    default:         zone_count_reg  <= zone_count_reg;
                endcase
            end

            if (out_valid_reg && !out_stall && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    if (clr_addr_reg == IDX_W'(ZONES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + IDX_W'(1);
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        sample_reg      <= sample_value;
                        sample_null_reg <= sample_is_null;
                        mag_reg         <= in_mag;
                        sq_reg          <= in_sq;
                        idx_reg         <= in_idx;
                        skip_reg        <= in_skip;
                        oor_reg         <= in_oor;
                        state_reg       <= S_READ;
                    end
                end
                S_READ:
                begin
                    if (load_out)
                    begin
                        out_valid_reg    <= 1'b1;
                        skipped_reg      <= skip_reg;
                        out_of_range_reg <= oor_reg;
                        if (skip_reg)
                        begin
                            zone_index_reg <= '0;
                            result_reg     <= '0;
                        end
                        else
                        begin
                            zone_index_reg <= 8'(idx_reg);
                            result_reg     <= upd_next;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign zone_index   = zone_index_reg;
    assign skipped      = skipped_reg;
    assign out_of_range = out_of_range_reg;
    assign cell_count   = result_reg.cell_count;
    assign valid_count  = result_reg.valid_count;
    assign sum          = result_reg.sum;
    assign sum_sq       = result_reg.sum_sq;
    assign sum_abs      = result_reg.sum_abs;
    assign minimum      = result_reg.minimum;
    assign maximum      = result_reg.maximum;

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_READ))
        else $error("accepted item did not enter table read");

    a_skip_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ && skip_reg) |-> !ram_wr_en)
        else $error("skipped item wrote the table");

    a_oor_is_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_of_range) |-> (skipped && cell_count == 32'd0))
        else $error("out-of-range result not marked skipped");

    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (valid_count <= cell_count))
        else $error("valid count exceeds cell count");

endmodule

// ===== verif/zonal_stats_accumulator_unit_test.sv =====
// Self-checking testbench for the zonal statistics accumulator with an in-bench table model.
`timescale 1ns / 1ps

module zonal_stats_accumulator_unit_test;

    import zsa_pkg::*;

    localparam int TABLE_DEPTH = ZONES_DEFAULT;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               sample_is_null;
        logic signed [31:0] zone_number;
        logic               zone_is_null;
    } raster_cell_t;

    typedef struct packed {
        logic [7:0] zone_index;
        logic       skipped;
        logic       out_of_range;
        zsa_entry_t stats;
    } zone_update_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write_en;
    zsa_reg_t               cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic signed [31:0]     sample_value;
    logic                   sample_is_null;
    logic signed [31:0]     zone_number;
    logic                   zone_is_null;
    logic                   out_valid;
    logic                   out_stall;
    logic [7:0]             zone_index;
    logic                   skipped;
    logic                   out_of_range;
    logic [31:0]            cell_count;
    logic [31:0]            valid_count;
    logic signed [63:0]     sum;
    logic [63:0]            sum_sq;
    logic [63:0]            sum_abs;
    logic signed [31:0]     minimum;
    logic signed [31:0]     maximum;

    zsa_entry_t             zone_table [TABLE_DEPTH];
    logic signed [31:0]     cfg_offset;
    logic [8:0]             cfg_count;
    zone_update_t           zone_stats_q [$];
    int                     error_count;
    bit                     in_idle_on;
    logic                   out_idle_on;
    logic                   hold_off;

    zonal_stats_accumulator_unit DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic zone_update_t predict_zone_update(input raster_cell_t c);
        zone_update_t r;
        int unsigned  span;
        longint       diff;
        int unsigned  idx;
        zsa_entry_t   e;
        logic [63:0]  mag;
        logic [64:0]  wide;
        r = '0;
        idx = 0;
        span = (cfg_count > TABLE_DEPTH) ? TABLE_DEPTH : cfg_count;
        if (span != 0)
        begin
            if (c.zone_is_null)
            begin
                r.skipped = 1'b1;
                return r;
            end
            diff = longint'($signed(c.zone_number)) - longint'($signed(cfg_offset));
            if (diff < 0 || diff >= longint'(span))
            begin
                r.skipped = 1'b1;
                r.out_of_range = 1'b1;
                return r;
            end
            idx = int'(diff);
        end
        e = zone_table[idx];
        if (e.cell_count != 32'hffff_ffff)
            e.cell_count = e.cell_count + 1;
        if (!c.sample_is_null)
        begin
            mag = {{32{c.sample_value[31]}}, c.sample_value};
            if (c.sample_value[31])
                mag = -mag;
            if (e.valid_count != 32'hffff_ffff)
                e.valid_count = e.valid_count + 1;
            wide = {e.sum[63], e.sum} + {{33{c.sample_value[31]}}, c.sample_value};
            if (wide[64] != wide[63])
                e.sum = wide[64] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
            else
                e.sum = wide[63:0];
            wide = {1'b0, e.sum_sq} + {1'b0, mag * mag};
            e.sum_sq = wide[64] ? 64'hffff_ffff_ffff_ffff : wide[63:0];
            wide = {1'b0, e.sum_abs} + {1'b0, mag};
            e.sum_abs = wide[64] ? 64'hffff_ffff_ffff_ffff : wide[63:0];
            if ($signed(c.sample_value) < $signed(e.minimum))
                e.minimum = c.sample_value;
            if ($signed(c.sample_value) > $signed(e.maximum))
                e.maximum = c.sample_value;
        end
        zone_table[idx] = e;
        r.zone_index = idx[7:0];
        r.stats = e;
        return r;
    endfunction

    function automatic raster_cell_t make_cell(input logic signed [31:0] value,
                                               input logic value_null,
                                               input logic signed [31:0] zone,
                                               input logic zone_null);
        raster_cell_t c;
        c.sample_value = value;
        c.sample_is_null = value_null;
        c.zone_number = zone;
        c.zone_is_null = zone_null;
        return c;
    endfunction

    function automatic raster_cell_t random_cell();
        raster_cell_t c;
        int unsigned  span;
        int unsigned  roll;
        span = (cfg_count > TABLE_DEPTH) ? TABLE_DEPTH : cfg_count;
        case ($urandom_range(9))
            0: c.sample_value = 32'sh8000_0000;
            1: c.sample_value = 32'sh7fff_ffff;
            2, 3: c.sample_value = int'($urandom_range(200)) - 100;
            default: c.sample_value = $urandom;
        endcase
        c.sample_is_null = ($urandom_range(99) < 15);
        c.zone_is_null = ($urandom_range(99) < 8);
        roll = $urandom_range(99);
        if (span != 0 && roll < 75)
            c.zone_number = cfg_offset + int'($urandom_range(span - 1));
        else if (roll < 88)
            c.zone_number = $urandom_range(1) ? cfg_offset - 1 : cfg_offset + int'(span);
        else
            c.zone_number = $urandom;
        return c;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        zone_update_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (zone_stats_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual zone_index %h",
                         $time, zone_index);
                error_count++;
            end
            else
            begin
                want = zone_stats_q.pop_front();
                check_field("zone_index", want.zone_index, zone_index);
                check_field("skipped", want.skipped, skipped);
                check_field("out_of_range", want.out_of_range, out_of_range);
                check_field("cell_count", want.stats.cell_count, cell_count);
                check_field("valid_count", want.stats.valid_count, valid_count);
                check_field("sum", want.stats.sum, sum);
                check_field("sum_sq", want.stats.sum_sq, sum_sq);
                check_field("sum_abs", want.stats.sum_abs, sum_abs);
                check_field("minimum", want.stats.minimum, minimum);
                check_field("maximum", want.stats.maximum, maximum);
            end
        end
        out_stall <= hold_off || (out_idle_on && $urandom_range(99) < 27);
    end

    task automatic send_cell(input raster_cell_t c);
        int gap;
        gap = 0;
        if (in_idle_on)
            while ($urandom_range(99) < 27)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        zone_stats_q.push_back(predict_zone_update(c));
        in_valid <= 1'b1;
        sample_value <= c.sample_value;
        sample_is_null <= c.sample_is_null;
        zone_number <= c.zone_number;
        zone_is_null <= c.zone_is_null;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (zone_stats_q.size() != 0);
    endtask

    task automatic write_config(input logic signed [31:0] offset, input logic [8:0] count);
        cfg_write_en <= 1'b1;
        cfg_index <= REG_ZONE_OFFSET;
        cfg_data <= offset;
        @(posedge clk);
        cfg_offset = offset;
        cfg_index <= REG_ZONE_COUNT;
        cfg_data <= CFG_DATA_W'(count);
        @(posedge clk);
        cfg_count = count;
        cfg_write_en <= 1'b0;
    endtask

    // zone fields ignored; extremes, null sample first, sum_sq driven into saturation
    task automatic test_zoning_off();
        write_config(32'sh1234_5678, 9'd0);
        send_cell(make_cell(32'sd5, 1'b1, $urandom, 1'b0));
        send_cell(make_cell(32'sd0, 1'b0, $urandom, 1'b1));
        send_cell(make_cell(32'sh7fff_ffff, 1'b0, $urandom, 1'b1));
        send_cell(make_cell(32'sh8000_0000, 1'b0, $urandom, 1'b0));
        send_cell(make_cell(-32'sd1, 1'b0, $urandom, 1'b0));
        send_cell(make_cell(32'sd1, 1'b0, $urandom, 1'b0));
        repeat (5) send_cell(make_cell(32'sh8000_0000, 1'b0, $urandom, 1'b0));
        wait_drained();
    endtask

    task automatic test_zone_ranges();
        write_config(32'sh7fff_ffff, 9'd1);
        send_cell(make_cell(32'sd7, 1'b0, 32'sh7fff_ffff, 1'b0));
        send_cell(make_cell(-32'sd3, 1'b0, 32'sh8000_0000, 1'b0));
        send_cell(make_cell(32'sd9, 1'b0, 32'sh7fff_ffff, 1'b1));
        wait_drained();
        // count above table size acts as full table
        write_config(32'sh8000_0000, 9'd511);
        send_cell(make_cell(32'sh7fff_ffff, 1'b0, 32'sh8000_0000, 1'b0));
        send_cell(make_cell(32'sh8000_0000, 1'b0, 32'sh8000_00ff, 1'b0));
        send_cell(make_cell(32'sd1, 1'b1, 32'sh8000_0100, 1'b0));
        send_cell(make_cell(32'sd1, 1'b0, 32'sh7fff_ffff, 1'b0));
        wait_drained();
        write_config(-32'sd5, 9'd10);
        send_cell(make_cell(32'sd11, 1'b0, -32'sd6, 1'b0));
        send_cell(make_cell(-32'sd12, 1'b0, -32'sd5, 1'b0));
        send_cell(make_cell(32'sd13, 1'b1, 32'sd4, 1'b0));
        send_cell(make_cell(32'sd14, 1'b0, 32'sd5, 1'b0));
        send_cell(make_cell(32'sd15, 1'b1, 32'sd0, 1'b1));
        wait_drained();
    endtask

    task automatic test_random_cells();
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_config($urandom, 9'd1);
                1: write_config($urandom, 9'd256);
                2: write_config(32'sh7fff_ff80, 9'd511);
                3: write_config($urandom, 9'd0);
                4: write_config($urandom, 9'($urandom_range(255, 2)));
                default: write_config(32'sh8000_0000, 9'd3);
            endcase
            in_idle_on = (phase != 1);
            out_idle_on <= (phase != 1);
            repeat (130) send_cell(random_cell());
            wait_drained();
        end
        in_idle_on = 1'b1;
        out_idle_on <= 1'b1;
    endtask

    task automatic test_backpressure();
        write_config(32'sd100, 9'd4);
        in_idle_on = 1'b0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (200) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
        repeat (60) send_cell(random_cell());
        wait_drained();
        in_idle_on = 1'b1;
        repeat (40) send_cell(random_cell());
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = REG_ZONE_OFFSET;
        cfg_data = '0;
        in_valid = 1'b0;
        sample_value = '0;
        sample_is_null = 1'b0;
        zone_number = '0;
        zone_is_null = 1'b0;
        hold_off = 1'b0;
        out_idle_on = 1'b1;
        in_idle_on = 1'b1;
        error_count = 0;
        cfg_offset = '0;
        cfg_count = '0;
        foreach (zone_table[i])
            zone_table[i] = ENTRY_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_zoning_off();
        test_zone_ranges();
        test_random_cells();
        test_backpressure();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
